// ===== sv/ir_sensor_normalizer_defines.svh =====
// Assertion macros for the file that checks this block.
`ifndef IR_SENSOR_NORMALIZER_DEFINES_SVH
`define IR_SENSOR_NORMALIZER_DEFINES_SVH

// Asserts that a condition implies a consequence in the same cycle.
`define IRN_ASSERT_IMPL(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error(msg);

// Asserts that a condition implies a consequence in the next cycle.
`define IRN_ASSERT_NEXT(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/irn_pkg.sv =====
package irn_pkg;

   localparam int FracBits = 8;
   localparam int ValW = 12 + FracBits;
   localparam int CalibSamples = 32;
   localparam int AttW = $clog2(CalibSamples + 1);
   localparam int SumW = 12 + AttW;
   localparam int ScaleW = 24;
   localparam int ProdW = 2 * ValW;
   localparam int AccW = ValW + 10;
   localparam int DivCntW = $clog2(ProdW + 1);
   localparam int QDepth = 2;

   localparam logic [1:0] REG_FILTER_ENABLE = 2'd0;
   localparam logic [1:0] REG_SMOOTHING_GAIN = 2'd1;
   localparam logic [1:0] REG_SAMPLE_OFFSET = 2'd2;
   localparam logic [1:0] REG_NOMINAL_REFERENCE = 2'd3;

   localparam logic [ValW-1:0] REF_RESET_RIGHT = ValW'(2900) << FracBits;
   localparam logic [ValW-1:0] REF_RESET_LEFT = ValW'(2700) << FracBits;

   // Classified item passed from the front part to the back part.
   typedef struct packed {
      logic            channel;
      logic [11:0]     adj;
      logic            read_failed;
      logic            calibrate;
   } work_type;

   typedef struct packed {
      logic               out_channel;
      logic               channel_valid;
      logic [11:0]        offset_removed;
      logic [ValW-1:0]    smoothed;
      logic [ScaleW-1:0]  normalized;
      logic [ValW-1:0]    current_reference;
      logic               calibration_done;
   } result_type;

endpackage

// ===== sv/ir_sensor_normalizer.sv =====
// Two-channel IR sample normalizer. Each item carries a channel, a 12-bit
// sample, a read-failure flag and a calibrate flag, and yields exactly one
// result that shows the channel's state after the item. Items enter a
// two-entry queue at up to one per cycle while not full; the back end then
// takes one item at a time. A failed sample or an ordinary calibration
// sample goes straight to the result; a normal sample is multiplied, then
// divided when the reference is above 1.0, and stored; the item that ends a
// calibration run first divides for the new reference (skipped when no read
// was valid), then goes on as a normal sample. The 40-step bit-serial divider
// forms filter * nominal / reference and the calibration average.
// Configuration registers must be written only while the block is idle.
`include "ir_sensor_normalizer_defines.svh"

module ir_sensor_normalizer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         full,
   input  logic                         req_channel,
   input  logic [11:0]                  req_sample,
   input  logic                         req_read_failed,
   input  logic                         req_calibrate,
   output logic                         empty,
   input  logic                         pop,
   output logic                         rsp_out_channel,
   output logic                         rsp_channel_valid,
   output logic [11:0]                  rsp_offset_removed,
   output logic [irn_pkg::ValW-1:0]     rsp_smoothed,
   output logic [irn_pkg::ScaleW-1:0]   rsp_normalized,
   output logic [irn_pkg::ValW-1:0]     rsp_current_reference,
   output logic                         rsp_calibration_done,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [1:0]                   csr_index,
   input  logic [31:0]                  csr_data
);

   // Configuration registers, written by index.
   logic                      fen_ff;
   logic [8:0]                gain_ff;
   logic [11:0]               off_ff;
   logic [irn_pkg::ValW-1:0]  nom_ff;

   logic                 work_valid, work_take, res_valid;
   irn_pkg::work_type    work_data;
   irn_pkg::result_type  res_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fen_ff <= 1'b0;
         gain_ff <= 9'd64;
         off_ff <= '0;
         nom_ff <= irn_pkg::ValW'(716800);
      end else if (csr_valid) begin
         case (csr_index)
            irn_pkg::REG_FILTER_ENABLE: fen_ff <= csr_data[0];
            irn_pkg::REG_SMOOTHING_GAIN: gain_ff <= csr_data[8:0];
            irn_pkg::REG_SAMPLE_OFFSET: off_ff <= csr_data[11:0];
            irn_pkg::REG_NOMINAL_REFERENCE: nom_ff <= csr_data[irn_pkg::ValW-1:0];
            default: ;
         endcase
      end
   end

   // The front part removes the offset and queues the classified item.
   irn_front u_front (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(full),
      .req_channel(req_channel), .req_sample(req_sample),
      .req_read_failed(req_read_failed), .req_calibrate(req_calibrate),
      .sample_offset(off_ff),
      .work_valid(work_valid), .work_take(work_take), .work_data(work_data)
   );

   // The back part updates channel state and holds the result register.
   irn_back u_back (
      .clock(clock), .reset(reset),
      .work_valid(work_valid), .work_take(work_take), .work_data(work_data),
      .filter_enable(fen_ff), .smoothing_gain(gain_ff),
      .nominal_reference(nom_ff),
      .res_valid(res_valid), .res_take(pop), .res_data(res_data)
   );

   assign empty = !res_valid;
   assign rsp_out_channel = res_data.out_channel;
   assign rsp_channel_valid = res_data.channel_valid;
   assign rsp_offset_removed = res_data.offset_removed;
   assign rsp_smoothed = res_data.smoothed;
   assign rsp_normalized = res_data.normalized;
   assign rsp_current_reference = res_data.current_reference;
   assign rsp_calibration_done = res_data.calibration_done;

   // A channel without a value never shows a nonzero normalized level.
   `IRN_ASSERT_IMPL(a_norm_needs_valid, !empty && !rsp_channel_valid, rsp_normalized == '0, "norm")
   // A waiting result stays on the ports until it is taken.
   `IRN_ASSERT_NEXT(a_rsp_holds, !empty && !pop, !empty && $stable(rsp_smoothed), "rsp held")
   // The back end only takes an item that the queue holds.
   `IRN_ASSERT_IMPL(a_front_hands_off, work_take, work_valid, "take from empty queue")

endmodule

// ===== sv/irn_front.sv =====
module irn_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic                 req_channel,
   input  logic [11:0]          req_sample,
   input  logic                 req_read_failed,
   input  logic                 req_calibrate,
   input  logic [11:0]          sample_offset,
   output logic                 work_valid,
   input  logic                 work_take,
   output irn_pkg::work_type    work_data
);

   irn_pkg::work_type q_ff [irn_pkg::QDepth];
   logic              rd_ff, wr_ff;
   logic [1:0]        cnt_ff;
   logic              push_ok, pop_ok;
   irn_pkg::work_type w;

   assign req_full = (cnt_ff == 2'(irn_pkg::QDepth));
   assign push_ok = req_push && !req_full;
   assign pop_ok = work_take && work_valid;
   assign work_valid = (cnt_ff != 2'd0);
   assign work_data = q_ff[rd_ff];

   always_comb begin
      w.channel = req_channel;
      w.adj = (req_sample > sample_offset) ? req_sample - sample_offset : 12'd0;
      w.read_failed = req_read_failed;
      w.calibrate = req_calibrate;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push_ok) wr_ff <= !wr_ff;
         if (pop_ok) rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + 2'(push_ok) - 2'(pop_ok);
      end
      if (push_ok) q_ff[wr_ff] <= w;
   end

endmodule

// ===== sv/irn_back.sv =====
module irn_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        work_valid,
   output logic                        work_take,
   input  irn_pkg::work_type           work_data,
   input  logic                        filter_enable,
   input  logic [8:0]                  smoothing_gain,
   input  logic [irn_pkg::ValW-1:0]    nominal_reference,
   output logic                        res_valid,
   input  logic                        res_take,
   output irn_pkg::result_type         res_data
);

   typedef enum logic [2:0] {
      S_IDLE, S_UPDATE, S_MUL, S_DIV, S_STORE, S_OUT
   } state_type;

   state_type state_ff;
   irn_pkg::work_type wk_ff;
   logic [irn_pkg::ValW-1:0]    filt_ff [2];
   logic                        vld_ff [2];
   logic [11:0]                 last_ff [2];
   logic [irn_pkg::ScaleW-1:0]  scl_ff [2];
   logic [irn_pkg::ValW-1:0]    ref_ff [2];
   logic [irn_pkg::SumW-1:0]    sum_ff [2];
   logic [irn_pkg::AttW-1:0]    att_ff [2];
   logic [irn_pkg::AttW-1:0]    good_ff [2];
   logic [irn_pkg::ProdW-1:0]   num_ff;
   logic [irn_pkg::ProdW-1:0]   den_ff;
   logic [irn_pkg::ProdW-1:0]   quo_ff;
   logic [irn_pkg::ProdW-1:0]   rem_ff;
   logic [irn_pkg::DivCntW-1:0] cnt_ff;
   logic          calib_ff;
   logic          done_ff;
   irn_pkg::result_type out_ff;
   logic          res_valid_ff;

   logic          c;
   logic [8:0]    a;
   logic [irn_pkg::AccW-1:0]   acc;
   logic [irn_pkg::ProdW:0]    rem_sh;
   logic [irn_pkg::ProdW:0]    rem_sub;
   logic [irn_pkg::ValW-1:0]   x;
   logic [irn_pkg::AttW-1:0]   att_nx;
   logic [irn_pkg::AttW-1:0]   good_nx;
   logic [irn_pkg::SumW-1:0]   sum_nx;
   logic [irn_pkg::ValW-1:0]   one;
   logic          out_load;

   assign c = wk_ff.channel;
   assign work_take = (state_ff == S_IDLE) && work_valid;
   assign res_valid = res_valid_ff;
   assign res_data = out_ff;
   assign out_load = (state_ff == S_OUT) && (!res_valid_ff || res_take);
   assign a = (smoothing_gain > 9'd256) ? 9'd256 : smoothing_gain;
   assign x = {wk_ff.adj, {irn_pkg::FracBits{1'b0}}};
   assign acc = irn_pkg::AccW'(9'd256 - a) * irn_pkg::AccW'(filt_ff[c])
                + irn_pkg::AccW'(a) * irn_pkg::AccW'(x)
                + irn_pkg::AccW'(128);
   assign rem_sh = {rem_ff, num_ff[irn_pkg::ProdW-1]};
   assign rem_sub = rem_sh - {1'b0, den_ff};
   assign att_nx = att_ff[c] + 1'b1;
   assign good_nx = good_ff[c] + irn_pkg::AttW'(!wk_ff.read_failed);
   assign sum_nx = sum_ff[c] + (wk_ff.read_failed ? '0 : irn_pkg::SumW'(wk_ff.adj));
   assign one = irn_pkg::ValW'(1) << irn_pkg::FracBits;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         res_valid_ff <= 1'b0;
         for (int i = 0; i < 2; i++) begin
            filt_ff[i] <= '0;
            vld_ff[i] <= 1'b0;
            last_ff[i] <= '0;
            scl_ff[i] <= '0;
            sum_ff[i] <= '0;
            att_ff[i] <= '0;
            good_ff[i] <= '0;
         end
         ref_ff[0] <= irn_pkg::REF_RESET_RIGHT;
         ref_ff[1] <= irn_pkg::REF_RESET_LEFT;
      end else begin
         if (out_load) res_valid_ff <= 1'b1;
         else if (res_take) res_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (work_valid) begin
                  wk_ff <= work_data;
                  state_ff <= S_UPDATE;
               end
            end
            S_UPDATE: begin
               if (wk_ff.calibrate) begin
                  if (att_nx >= irn_pkg::AttW'(irn_pkg::CalibSamples)) begin
                     sum_ff[c] <= '0;
                     att_ff[c] <= '0;
                     good_ff[c] <= '0;
                     done_ff <= 1'b1;
                     calib_ff <= 1'b1;
                     num_ff <= irn_pkg::ProdW'({sum_nx, {irn_pkg::FracBits{1'b0}}})
                               + irn_pkg::ProdW'(good_nx >> 1);
                     den_ff <= irn_pkg::ProdW'(good_nx);
                     rem_ff <= '0;
                     cnt_ff <= irn_pkg::DivCntW'(irn_pkg::ProdW);
                     state_ff <= (good_nx == '0) ? S_STORE : S_DIV;
                  end else begin
                     sum_ff[c] <= sum_nx;
                     att_ff[c] <= att_nx;
                     good_ff[c] <= good_nx;
                     done_ff <= 1'b0;
                     state_ff <= S_OUT;
                  end
               end else if (!wk_ff.read_failed) begin
                  last_ff[c] <= wk_ff.adj;
                  vld_ff[c] <= 1'b1;
                  if (!vld_ff[c] || !filter_enable) filt_ff[c] <= x;
                  else filt_ff[c] <= acc[irn_pkg::ValW+7:8];
                  done_ff <= 1'b0;
                  calib_ff <= 1'b0;
                  state_ff <= S_MUL;
               end else begin
                  done_ff <= 1'b0;
                  state_ff <= S_OUT;
               end
            end
            S_MUL: begin
               num_ff <= filt_ff[c] * nominal_reference;
               den_ff <= irn_pkg::ProdW'(ref_ff[c]);
               rem_ff <= '0;
               cnt_ff <= irn_pkg::DivCntW'(irn_pkg::ProdW);
               state_ff <= (ref_ff[c] > one) ? S_DIV : S_STORE;
            end
            S_DIV: begin
               if (rem_sh >= {1'b0, den_ff}) begin
                  rem_ff <= rem_sub[irn_pkg::ProdW-1:0];
                  quo_ff <= {quo_ff[irn_pkg::ProdW-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh[irn_pkg::ProdW-1:0];
                  quo_ff <= {quo_ff[irn_pkg::ProdW-2:0], 1'b0};
               end
               num_ff <= num_ff << 1;
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == irn_pkg::DivCntW'(1)) state_ff <= S_STORE;
            end
            S_STORE: begin
               if (calib_ff) begin
                  ref_ff[c] <= (den_ff == '0) ? '0 : quo_ff[irn_pkg::ValW-1:0];
                  calib_ff <= 1'b0;
                  state_ff <= S_MUL;
               end else begin
                  if (!vld_ff[c]) scl_ff[c] <= '0;
                  else if (ref_ff[c] > one) begin
                     scl_ff[c] <= (quo_ff > irn_pkg::ProdW'({irn_pkg::ScaleW{1'b1}}))
                                  ? '1 : quo_ff[irn_pkg::ScaleW-1:0];
                  end else scl_ff[c] <= irn_pkg::ScaleW'(filt_ff[c]);
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_load) begin
                  out_ff.out_channel <= c;
                  out_ff.channel_valid <= vld_ff[c];
                  out_ff.offset_removed <= last_ff[c];
                  out_ff.smoothed <= filt_ff[c];
                  out_ff.normalized <= scl_ff[c];
                  out_ff.current_reference <= ref_ff[c];
                  out_ff.calibration_done <= done_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
